// File: src/jml_pkg.sv
`timescale 1ns / 1ps

package jml_pkg;

  // Fixed-point format of all velocity, position and limit values
  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;

  // Command kinds
  typedef enum logic [1:0] {
    KIND_SPEED = 2'd0,
    KIND_ACCEL = 2'd1,
    KIND_BRAKE = 2'd2,
    KIND_POS   = 2'd3
  } kind_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 3'd0,
    REG_LOWER = 3'd1,
    REG_SPEED = 3'd2,
    REG_ACCEL = 3'd3,
    REG_MULT  = 3'd4,
    REG_STEP  = 3'd5
  } reg_idx_t;

  // Configuration seen by the datapath
  typedef struct packed {
    logic [31:0] upper_limit;
    logic [31:0] lower_limit;
    logic [30:0] speed_limit;
    logic [30:0] accel_limit;
    logic [30:0] speed_multiplier;
    logic [15:0] time_step;
    logic        unlimited;
    logic [30:0] accel_eff;
  } cfg_t;

endpackage

// File: src/jml_cfg.sv
`timescale 1ns / 1ps

module jml_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [jml_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jml_pkg::DATA_W-1:0]     cfg_wr_data,
  output jml_pkg::cfg_t                  cfg
);

  logic [31:0] upper_r;
  logic [31:0] lower_r;
  logic [30:0] speed_r;
  logic [30:0] accel_r;
  logic [30:0] mult_r;
  logic [15:0] step_r;

  // Decode writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r <= 32'd0;
      lower_r <= 32'd0;
      speed_r <= 31'd0;
      accel_r <= 31'd65536;
      mult_r  <= 31'd65536;
      step_r  <= 16'd66;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        jml_pkg::REG_UPPER: upper_r <= cfg_wr_data;
        jml_pkg::REG_LOWER: lower_r <= cfg_wr_data;
        jml_pkg::REG_SPEED: speed_r <= cfg_wr_data[30:0];
        jml_pkg::REG_ACCEL: accel_r <= cfg_wr_data[30:0];
        jml_pkg::REG_MULT:  mult_r  <= cfg_wr_data[30:0];
        jml_pkg::REG_STEP:  step_r  <= cfg_wr_data[15:0];
        default: ;
      endcase
    end
  end

  // Publish registers with the derived flags
  always_comb begin
    cfg.upper_limit      = upper_r;
    cfg.lower_limit      = lower_r;
    cfg.speed_limit      = speed_r;
    cfg.accel_limit      = accel_r;
    cfg.speed_multiplier = mult_r;
    cfg.time_step        = step_r;
    cfg.unlimited        = (upper_r == 32'd0) && (lower_r == 32'd0);
    cfg.accel_eff        = (accel_r == 31'd0) ? 31'd1 : accel_r;
  end

endmodule

// File: src/joint_motion_limiter_unit.sv
`timescale 1ns / 1ps

// Takes one command per cycle while in_stall is low.
// Six register stages: capture, speed or position clamp, acceleration window, prediction,
// braking-distance partial products, braking compare and output register.
// Each stage takes a new command when it is empty or its successor advances.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
module joint_motion_limiter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [jml_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jml_pkg::DATA_W-1:0]     cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_kind,
  input  logic signed [31:0]             in_target_value,
  input  logic signed [31:0]             in_actual_velocity,
  input  logic signed [31:0]             in_actual_position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [31:0]             out_limited_value,
  output logic                           out_was_limited
);

  localparam int NSTG = 6;
  localparam int KW   = 34;
  localparam int KLO  = KW / 2;

  jml_pkg::cfg_t cfg;

  jml_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  logic signed [31:0] up_s;
  logic signed [31:0] lo_s;
  assign up_s = $signed(cfg.upper_limit);
  assign lo_s = $signed(cfg.lower_limit);

  // ---------------------------------------------------------------
  // Stage control
  // ---------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: capture, speed bound product
  // ---------------------------------------------------------------
  jml_pkg::kind_t     s1_kind_r;
  logic signed [31:0] s1_tv_r;
  logic signed [31:0] s1_av_r;
  logic signed [31:0] s1_ap_r;
  logic [61:0]        s1_pl_r;
  logic [61:0]        s1_pl_nxt;

  assign s1_pl_nxt = cfg.speed_limit * cfg.speed_multiplier;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_kind_r <= jml_pkg::kind_t'(in_kind);
      s1_tv_r   <= in_target_value;
      s1_av_r   <= in_actual_velocity;
      s1_ap_r   <= in_actual_position;
      s1_pl_r   <= s1_pl_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: speed clamp or position clamp, acceleration step product
  // ---------------------------------------------------------------
  logic [61:0]        lim_wide;
  logic [30:0]        lim;
  logic [31:0]        tv_mag;
  logic signed [31:0] s2_v_nxt;
  logic               s2_flag_nxt;
  logic [46:0]        s2_ps_nxt;

  jml_pkg::kind_t     s2_kind_r;
  logic signed [31:0] s2_v_r;
  logic               s2_flag_r;
  logic signed [31:0] s2_av_r;
  logic signed [31:0] s2_ap_r;
  logic [46:0]        s2_ps_r;

  always_comb begin
    lim_wide    = s1_pl_r >> jml_pkg::FRAC_BITS;
    lim         = (|lim_wide[61:31]) ? '1 : lim_wide[30:0];
    tv_mag      = s1_tv_r[31] ? 32'(-s1_tv_r) : 32'(s1_tv_r);
    s2_v_nxt    = s1_tv_r;
    s2_flag_nxt = 1'b0;
    s2_ps_nxt   = cfg.accel_limit * cfg.time_step;
    if (s1_kind_r == jml_pkg::KIND_POS) begin
      if (!cfg.unlimited) begin
        if (s1_tv_r > up_s) begin
          s2_v_nxt    = up_s;
          s2_flag_nxt = 1'b1;
        end else if (s1_tv_r < lo_s) begin
          s2_v_nxt    = lo_s;
          s2_flag_nxt = 1'b1;
        end
      end
    end else if (tv_mag > {1'b0, lim}) begin
      s2_v_nxt    = s1_tv_r[31] ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
      s2_flag_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_kind_r <= s1_kind_r;
      s2_v_r    <= s2_v_nxt;
      s2_flag_r <= s2_flag_nxt;
      s2_av_r   <= s1_av_r;
      s2_ap_r   <= s1_ap_r;
      s2_ps_r   <= s2_ps_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: acceleration window, travel-per-step product
  // ---------------------------------------------------------------
  logic [46:0]        st_wide;
  logic [30:0]        st;
  logic signed [33:0] sup_w;
  logic signed [33:0] inf_w;
  logic signed [31:0] sup;
  logic signed [31:0] inf;
  logic signed [31:0] s3_v_nxt;
  logic               s3_flag_nxt;
  logic signed [48:0] s3_pp_nxt;

  jml_pkg::kind_t     s3_kind_r;
  logic signed [31:0] s3_v_r;
  logic               s3_flag_r;
  logic [30:0]        s3_st_r;
  logic signed [31:0] s3_ap_r;
  logic signed [48:0] s3_pp_r;

  always_comb begin
    st_wide = s2_ps_r >> jml_pkg::FRAC_BITS;
    st      = (|st_wide[46:31]) ? '1 : st_wide[30:0];
    sup_w   = $signed({{2{s2_av_r[31]}}, s2_av_r}) + $signed({3'b000, st});
    inf_w   = $signed({{2{s2_av_r[31]}}, s2_av_r}) - $signed({3'b000, st});
    // saturate window bounds to 32 bits
    if (sup_w[33:31] == 3'b000 || sup_w[33:31] == 3'b111) sup = sup_w[31:0];
    else sup = sup_w[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    if (inf_w[33:31] == 3'b000 || inf_w[33:31] == 3'b111) inf = inf_w[31:0];
    else inf = inf_w[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    s3_v_nxt    = s2_v_r;
    s3_flag_nxt = s2_flag_r;
    if (s2_kind_r == jml_pkg::KIND_ACCEL || s2_kind_r == jml_pkg::KIND_BRAKE) begin
      if (s2_v_r > sup) begin
        s3_v_nxt    = sup;
        s3_flag_nxt = 1'b1;
      end else if (s2_v_r < inf) begin
        s3_v_nxt    = inf;
        s3_flag_nxt = 1'b1;
      end
    end
    s3_pp_nxt = s2_av_r * $signed({1'b0, cfg.time_step});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_kind_r <= s2_kind_r;
      s3_v_r    <= s3_v_nxt;
      s3_flag_r <= s3_flag_nxt;
      s3_st_r   <= st;
      s3_ap_r   <= s2_ap_r;
      s3_pp_r   <= s3_pp_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: predicted position, margin to the limit, v squared
  // ---------------------------------------------------------------
  logic signed [48:0] pp_sh;
  logic signed [31:0] pp_sat;
  logic signed [33:0] pred;
  logic [31:0]        v_mag;
  logic               v_pos;
  logic [63:0]        s4_nn_nxt;
  logic signed [34:0] s4_x_nxt;
  logic               s4_cand_nxt;

  jml_pkg::kind_t     s4_kind_r;
  logic signed [31:0] s4_v_r;
  logic               s4_flag_r;
  logic [30:0]        s4_st_r;
  logic [63:0]        s4_nn_r;
  logic signed [34:0] s4_x_r;
  logic               s4_cand_r;

  always_comb begin
    pp_sh = s3_pp_r >>> jml_pkg::FRAC_BITS;
    if (pp_sh[48:31] == '0 || pp_sh[48:31] == '1) pp_sat = pp_sh[31:0];
    else pp_sat = pp_sh[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    pred      = $signed({{2{s3_ap_r[31]}}, s3_ap_r}) + $signed({{2{pp_sat[31]}}, pp_sat});
    v_mag     = s3_v_r[31] ? 32'(-s3_v_r) : 32'(s3_v_r);
    v_pos     = !s3_v_r[31] && (|s3_v_r);
    s4_nn_nxt = v_mag * v_mag;
    // margin toward the limit the velocity moves to
    if (v_pos) s4_x_nxt = $signed({{3{up_s[31]}}, up_s}) - $signed({pred[33], pred});
    else       s4_x_nxt = $signed({pred[33], pred}) - $signed({{3{lo_s[31]}}, lo_s});
    s4_cand_nxt = (s3_kind_r == jml_pkg::KIND_BRAKE) && !cfg.unlimited && (|s3_v_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_kind_r <= s3_kind_r;
      s4_v_r    <= s3_v_r;
      s4_flag_r <= s3_flag_r;
      s4_st_r   <= s3_st_r;
      s4_nn_r   <= s4_nn_nxt;
      s4_x_r    <= s4_x_nxt;
      s4_cand_r <= s4_cand_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: accel times (margin + 1), split in two partial products
  // Braking acts on a braking command when
  // floor(v*v / 2) >= accel * (margin + 1) or the margin is negative.
  // ---------------------------------------------------------------
  logic signed [34:0] kp1;
  logic [47:0]        s5_plo_nxt;
  logic [47:0]        s5_phi_nxt;

  jml_pkg::kind_t     s5_kind_r;
  logic signed [31:0] s5_v_r;
  logic               s5_flag_r;
  logic [30:0]        s5_st_r;
  logic [62:0]        s5_half_r;
  logic               s5_xneg_r;
  logic [47:0]        s5_plo_r;
  logic [47:0]        s5_phi_r;
  logic               s5_cand_r;

  always_comb begin
    kp1        = s4_x_r + 35'sd1;
    s5_plo_nxt = cfg.accel_eff * kp1[KLO-1:0];
    s5_phi_nxt = cfg.accel_eff * kp1[KW-1:KLO];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_kind_r <= s4_kind_r;
      s5_v_r    <= s4_v_r;
      s5_flag_r <= s4_flag_r;
      s5_st_r   <= s4_st_r;
      s5_half_r <= s4_nn_r[63:1];
      s5_xneg_r <= s4_x_r[34];
      s5_plo_r  <= s5_plo_nxt;
      s5_phi_r  <= s5_phi_nxt;
      s5_cand_r <= s4_cand_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 6: braking compare and step toward zero, output register
  // ---------------------------------------------------------------
  logic [65:0]        prod;
  logic               hit;
  logic signed [32:0] dv;
  logic signed [31:0] s6_v_nxt;
  logic               s6_flag_nxt;

  jml_pkg::kind_t     s6_kind_r;
  logic signed [31:0] s6_v_r;
  logic               s6_flag_r;
  logic               s6_brake_r;

  always_comb begin
    prod = {{(66 - 48 - KLO){1'b0}}, s5_phi_r, {KLO{1'b0}}} + {18'd0, s5_plo_r};
    hit  = s5_cand_r && (s5_xneg_r || ({3'b000, s5_half_r} >= prod));
    s6_v_nxt    = s5_v_r;
    s6_flag_nxt = s5_flag_r;
    dv          = '0;
    if (hit) begin
      s6_flag_nxt = 1'b1;
      if (!s5_v_r[31]) begin
        dv       = $signed({s5_v_r[31], s5_v_r}) - $signed({2'b00, s5_st_r});
        s6_v_nxt = dv[32] ? 32'sd0 : dv[31:0];
      end else begin
        dv       = $signed({s5_v_r[31], s5_v_r}) + $signed({2'b00, s5_st_r});
        s6_v_nxt = (!dv[32] && (|dv)) ? 32'sd0 : dv[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_kind_r  <= s5_kind_r;
      s6_v_r     <= s6_v_nxt;
      s6_flag_r  <= s6_flag_nxt;
      s6_brake_r <= hit;
    end
  end

  assign out_valid         = vld_r[NSTG-1];
  assign out_limited_value = s6_v_r;
  assign out_was_limited   = s6_flag_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && out_stall |-> in_stall)
    else $error("input accepted while pipeline full and output stalled");

  a_brake_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && s6_brake_r |-> out_was_limited && (s6_kind_r == jml_pkg::KIND_BRAKE))
    else $error("braking acted on a non-braking command or left flag clear");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0) && !in_stall)
    else $error("pipeline not empty after reset");

endmodule
